FILE: src/hdd_pkg.sv
// Shared constants, command and status types for the Huffman difference decoder.
`default_nettype none

package hdd_pkg;

  localparam int TREE_NODES_DEF = 511;
  localparam int MAX_CODE_BITS  = 8;
  localparam int MAX_EXTRA_BITS = 16;
  localparam int EXTRA_W        = 16;
  localparam int DIFF_W         = 17;
  localparam int SYM_W          = 5;
  localparam int LEN_W          = 4;
  localparam int BYTE_W         = 8;
  localparam logic [SYM_W-1:0] NO_SYMBOL = 5'd31;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic ld_step;
    logic empty_err;
    logic walk_step;
    logic fetch_step;
    logic check_step;
    logic flush_step;
  } hdd_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ld_ok;
    logic ld_last;
    logic tree_empty;
    logic need_fetch;
    logic bits_done;
    logic emit_ok;
    logic hold_v;
    logic reading;
    logic walk_root;
  } hdd_stat_t;

endpackage

`default_nettype wire

FILE: src/hdd_ctrl.sv
// Controller state machine: table clear sweep, load steps and per-bit decode sequencing.
`default_nettype none

module hdd_ctrl
  import hdd_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_mode,
  output logic       in_stall,
  input  wire hdd_stat_t stat,
  output hdd_cmd_t   cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_BYTE  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_mode ? S_BYTE : S_LOAD;
        end
      end
      S_LOAD: begin
        if (!stat.ld_ok) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ld_step = 1'b1;
          if (stat.ld_last) state_nxt = S_IDLE;
        end
      end
      S_BYTE: begin
        if (stat.emit_ok) begin
          if (stat.tree_empty) begin
            cmd.empty_err = 1'b1;
            state_nxt     = S_FLUSH;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat.bits_done) begin
          state_nxt = S_CHECK;
        end else if (stat.emit_ok) begin
          cmd.walk_step = 1'b1;
          if (stat.need_fetch) state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.emit_ok) begin
          cmd.fetch_step = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_CHECK: begin
        if (stat.emit_ok) begin
          cmd.check_step = 1'b1;
          state_nxt      = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.emit_ok) begin
          cmd.flush_step = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/hdd_dp.sv
// Datapath: code tree memories, walk and extra-bit registers, result hold and output stage.
`default_nettype none

module hdd_dp
  import hdd_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire  [LEN_W-1:0]         in_code_length,
  input  wire  [BYTE_W-1:0]        in_code_bits,
  input  wire  [SYM_W-1:0]         in_symbol,
  input  wire  [BYTE_W-1:0]        in_data_byte,
  input  wire                      in_final_byte,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [DIFF_W-1:0] out_diff_value,
  output logic                     out_error,
  output logic                     out_last,
  input  wire hdd_cmd_t            cmd,
  output hdd_stat_t                stat
);

  localparam int NW = $clog2(TREE_NODES);

  logic             c0_mem [0:TREE_NODES-1];
  logic             c1_mem [0:TREE_NODES-1];
  logic [SYM_W-1:0] sym_mem [0:TREE_NODES-1];

  logic             c0_rd_r;
  logic             c1_rd_r;
  logic [SYM_W-1:0] sym_rd_r;

  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] code_r;
  logic [SYM_W-1:0]  sym_r;
  logic              fin_r;

  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [3:0]         bitcnt_r, bitcnt_nxt;
  logic [NW-1:0]      walk_r, walk_nxt;
  logic [1:0]         cur_cp_r, cur_cp_nxt;
  logic [1:0]         root_cp_r, root_cp_nxt;
  logic               reading_r, reading_nxt;
  logic [SYM_W-1:0]   left_r, left_nxt;
  logic [SYM_W-1:0]   total_r, total_nxt;
  logic [EXTRA_W-1:0] accum_r, accum_nxt;
  logic [NW-1:0]      child_r, child_nxt;
  logic [NW-1:0]      ld_node_r, ld_node_nxt;
  logic [2:0]         ld_lvl_r, ld_lvl_nxt;
  logic [NW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [DIFF_W-1:0]  hold_val_r, hold_val_nxt;
  logic               hold_err_r, hold_err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DIFF_W-1:0]  out_val_r, out_val_nxt;
  logic               out_err_r, out_err_nxt;
  logic               out_last_r, out_last_nxt;

  logic               bit_in;
  logic [NW:0]        child_wide;
  logic [NW-1:0]      child_addr;
  logic               ld_dir;
  logic [NW:0]        ld_child_wide;
  logic [NW-1:0]      ld_child;
  logic [9:0]         fin_node;
  logic [SYM_W-1:0]   sym_clamp;
  logic               out_free;
  logic               emit_v;
  logic [DIFF_W-1:0]  emit_val;
  logic               emit_err;
  logic [EXTRA_W-1:0] accum_ext;
  logic [SYM_W-1:0]   left_dec;
  logic [3:0]         tidx;
  logic               first_bit;
  logic [DIFF_W-1:0]  mask;
  logic [1:0]         fetch_cp;
  logic               rd_en;
  logic               c0_we;
  logic               c1_we;
  logic               sym_we;
  logic [NW-1:0]      c_wa;
  logic               c_wd;
  logic [NW-1:0]      sym_wa;
  logic [SYM_W-1:0]   sym_wd;

  assign bit_in        = shift_r[BYTE_W-1];
  assign child_wide    = {walk_r, 1'b0} + {{NW{1'b0}}, 1'b1} + {{NW{1'b0}}, bit_in};
  assign child_addr    = child_wide[NW-1:0];
  assign ld_dir        = code_r[3'd7 - ld_lvl_r];
  assign ld_child_wide = {ld_node_r, 1'b0} + {{NW{1'b0}}, 1'b1} + {{NW{1'b0}}, ld_dir};
  assign ld_child      = ld_child_wide[NW-1:0];
  assign fin_node      = ((10'd1 << len_r) - 10'd1) + ({2'b00, code_r} >> (4'd8 - len_r));
  assign sym_clamp     = (sym_r > SYM_W'(MAX_EXTRA_BITS)) ? SYM_W'(MAX_EXTRA_BITS) : sym_r;
  assign out_free      = !out_valid_r || !out_stall;
  assign fetch_cp      = {c1_rd_r, c0_rd_r};

  assign accum_ext = {accum_r[EXTRA_W-2:0], bit_in};
  assign left_dec  = (left_r != '0) ? left_r - SYM_W'(1) : '0;
  assign tidx      = 4'(total_r - SYM_W'(1));
  assign first_bit = accum_ext[tidx];
  assign mask      = (DIFF_W'(1) << total_r) - DIFF_W'(1);

  assign stat.clr_last   = (clr_addr_r == NW'(TREE_NODES - 1));
  assign stat.ld_ok      = (len_r != '0) && (len_r <= LEN_W'(MAX_CODE_BITS))
                           && (fin_node < 10'(TREE_NODES));
  assign stat.ld_last    = ({1'b0, ld_lvl_r} == len_r - LEN_W'(1));
  assign stat.tree_empty = !reading_r && (walk_r == '0) && (root_cp_r == 2'b00);
  assign stat.need_fetch = !reading_r && cur_cp_r[bit_in];
  assign stat.bits_done  = (bitcnt_r == 4'd8);
  assign stat.emit_ok    = !hold_v_r || out_free;
  assign stat.hold_v     = hold_v_r;
  assign stat.reading    = reading_r;
  assign stat.walk_root  = (walk_r == '0);

  assign rd_en  = cmd.walk_step && stat.need_fetch;
  assign c_wa   = cmd.clr_wr ? clr_addr_r : ld_node_r;
  assign c_wd   = !cmd.clr_wr;
  assign c0_we  = cmd.clr_wr || (cmd.ld_step && !ld_dir);
  assign c1_we  = cmd.clr_wr || (cmd.ld_step && ld_dir);
  assign sym_wa = cmd.clr_wr ? clr_addr_r : ld_child;
  assign sym_we = cmd.clr_wr || (cmd.ld_step && stat.ld_last);
  assign sym_wd = cmd.clr_wr ? NO_SYMBOL : sym_clamp;

  always_ff @(posedge clk) begin
    if (c0_we) c0_mem[c_wa] <= c_wd;
    if (c1_we) c1_mem[c_wa] <= c_wd;
    if (sym_we) sym_mem[sym_wa] <= sym_wd;
    if (rd_en) begin
      c0_rd_r  <= c0_mem[child_addr];
      c1_rd_r  <= c1_mem[child_addr];
      sym_rd_r <= sym_mem[child_addr];
    end
  end

  always_comb begin
    shift_nxt    = shift_r;
    bitcnt_nxt   = bitcnt_r;
    walk_nxt     = walk_r;
    cur_cp_nxt   = cur_cp_r;
    root_cp_nxt  = root_cp_r;
    reading_nxt  = reading_r;
    left_nxt     = left_r;
    total_nxt    = total_r;
    accum_nxt    = accum_r;
    child_nxt    = child_r;
    ld_node_nxt  = ld_node_r;
    ld_lvl_nxt   = ld_lvl_r;
    clr_addr_nxt = clr_addr_r;
    hold_v_nxt   = hold_v_r;
    hold_val_nxt = hold_val_r;
    hold_err_nxt = hold_err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_val_nxt  = out_val_r;
    out_err_nxt  = out_err_r;
    out_last_nxt = out_last_r;
    emit_v       = 1'b0;
    emit_val     = '0;
    emit_err     = 1'b0;

    if (cmd.clr_wr) clr_addr_nxt = clr_addr_r + NW'(1);

    if (cmd.accept) begin
      shift_nxt   = in_data_byte;
      bitcnt_nxt  = '0;
      ld_node_nxt = '0;
      ld_lvl_nxt  = '0;
    end

    if (cmd.ld_step) begin
      if (ld_node_r == '0) root_cp_nxt = root_cp_r | {ld_dir, !ld_dir};
      if (ld_node_r == walk_r) cur_cp_nxt = cur_cp_r | {ld_dir, !ld_dir};
      ld_node_nxt = ld_child;
      ld_lvl_nxt  = ld_lvl_r + 3'd1;
    end

    if (cmd.empty_err) begin
      emit_v   = 1'b1;
      emit_err = 1'b1;
    end

    if (cmd.walk_step) begin
      shift_nxt  = {shift_r[BYTE_W-2:0], 1'b0};
      bitcnt_nxt = bitcnt_r + 4'd1;
      if (reading_r) begin
        accum_nxt = accum_ext;
        left_nxt  = left_dec;
        if (left_dec == '0) begin
          emit_v      = 1'b1;
          emit_val    = {1'b0, accum_ext} - (first_bit ? '0 : mask);
          reading_nxt = 1'b0;
          left_nxt    = '0;
          total_nxt   = '0;
          accum_nxt   = '0;
          walk_nxt    = '0;
          cur_cp_nxt  = root_cp_r;
        end
      end else if (!cur_cp_r[bit_in]) begin
        emit_v     = 1'b1;
        emit_err   = 1'b1;
        walk_nxt   = '0;
        cur_cp_nxt = root_cp_r;
      end else begin
        child_nxt = child_addr;
      end
    end

    if (cmd.fetch_step) begin
      if (fetch_cp != 2'b00) begin
        walk_nxt   = child_r;
        cur_cp_nxt = fetch_cp;
      end else begin
        walk_nxt   = '0;
        cur_cp_nxt = root_cp_r;
        if (sym_rd_r > SYM_W'(MAX_EXTRA_BITS)) begin
          emit_v   = 1'b1;
          emit_err = 1'b1;
        end else if (sym_rd_r == '0) begin
          emit_v = 1'b1;
        end else begin
          reading_nxt = 1'b1;
          left_nxt    = sym_rd_r;
          total_nxt   = sym_rd_r;
          accum_nxt   = '0;
        end
      end
    end

    if (cmd.check_step && fin_r && (reading_r || walk_r != '0)) begin
      emit_v   = 1'b1;
      emit_err = 1'b1;
    end

    if (emit_v) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = hold_val_r;
        out_err_nxt   = hold_err_r;
        out_last_nxt  = 1'b0;
      end
      hold_v_nxt   = 1'b1;
      hold_val_nxt = emit_val;
      hold_err_nxt = emit_err;
    end

    if (cmd.flush_step) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_val_nxt   = hold_val_r;
        out_err_nxt   = hold_err_r;
        out_last_nxt  = 1'b1;
        hold_v_nxt    = 1'b0;
      end
      if (fin_r) begin
        walk_nxt    = '0;
        cur_cp_nxt  = root_cp_r;
        reading_nxt = 1'b0;
        left_nxt    = '0;
        total_nxt   = '0;
        accum_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      len_r  <= in_code_length;
      code_r <= in_code_bits;
      sym_r  <= in_symbol;
      fin_r  <= in_final_byte;
    end
    shift_r    <= shift_nxt;
    child_r    <= child_nxt;
    ld_node_r  <= ld_node_nxt;
    ld_lvl_r   <= ld_lvl_nxt;
    hold_val_r <= hold_val_nxt;
    hold_err_r <= hold_err_nxt;
    out_val_r  <= out_val_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitcnt_r    <= '0;
      walk_r      <= '0;
      cur_cp_r    <= '0;
      root_cp_r   <= '0;
      reading_r   <= 1'b0;
      left_r      <= '0;
      total_r     <= '0;
      accum_r     <= '0;
      clr_addr_r  <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bitcnt_r    <= bitcnt_nxt;
      walk_r      <= walk_nxt;
      cur_cp_r    <= cur_cp_nxt;
      root_cp_r   <= root_cp_nxt;
      reading_r   <= reading_nxt;
      left_r      <= left_nxt;
      total_r     <= total_nxt;
      accum_r     <= accum_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_diff_value = $signed(out_val_r);
  assign out_error      = out_err_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

FILE: src/huffman_difference_decoder.sv
// Lossless-JPEG style Huffman difference decoder: top level, controller and datapath.
// After reset the block sweeps all TREE_NODES nodes of its code tree memory (511 by default),
// one node per cycle, and holds in_stall high until the sweep ends. A table-load item is
// accepted and then sets the child flags along its path, one code bit (up to 8) per step; an
// ignored entry is accepted and checked only, and writes nothing. A data byte is accepted and
// dispatched; each bit then takes a walk step that reads an extra difference bit, hits a
// missing branch or steps to a child, and a step to a child is followed by a fetch step (a
// registered read of the node memory); a check step and a flush step close the byte. When the
// tree is empty the byte gives one error result and goes straight to the flush step. Each
// result is held back one step so that the last one of a byte can be marked; out_stall holds
// the decoder while both the hold stage and the output register are full.
`default_nettype none

module huffman_difference_decoder
  import hdd_pkg::*;
#(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      in_mode,
  input  wire  [LEN_W-1:0]         in_code_length,
  input  wire  [BYTE_W-1:0]        in_code_bits,
  input  wire  [SYM_W-1:0]         in_symbol,
  input  wire  [BYTE_W-1:0]        in_data_byte,
  input  wire                      in_final_byte,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [DIFF_W-1:0] out_diff_value,
  output logic                     out_error,
  output logic                     out_last
);

  hdd_cmd_t  cmd;
  hdd_stat_t stat;

  hdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  hdd_dp #(
    .TREE_NODES (TREE_NODES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_code_length (in_code_length),
    .in_code_bits   (in_code_bits),
    .in_symbol      (in_symbol),
    .in_data_byte   (in_data_byte),
    .in_final_byte  (in_final_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_diff_value (out_diff_value),
    .out_error      (out_error),
    .out_last       (out_last),
    .cmd            (cmd),
    .stat           (stat)
  );

  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !stat.hold_v)
    else $error("result still held while ready for a transfer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_diff_value == '0))
    else $error("error result with nonzero difference");

  a_extra_at_root: assert property (@(posedge clk) disable iff (!rst_n)
    stat.reading |-> stat.walk_root)
    else $error("extra bits read while tree walk is off the root");

endmodule

`default_nettype wire

FILE: tb/hdd_tb_pkg.sv
`timescale 1ns / 1ps
// Input item kinds shared by the Huffman difference decoder testbench files.
package hdd_tb_pkg;

  typedef enum logic {
    HDD_LOAD = 1'b0,
    HDD_DATA = 1'b1
  } hdd_mode_e;

endpackage

FILE: tb/hdd_checker.sv
`timescale 1ns / 1ps
// Channel monitor that predicts decoded differences per input transfer and checks results.
module hdd_checker
  import hdd_pkg::*, hdd_tb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_mode,
  input  logic [LEN_W-1:0]         in_code_length,
  input  logic [BYTE_W-1:0]        in_code_bits,
  input  logic [SYM_W-1:0]         in_symbol,
  input  logic [BYTE_W-1:0]        in_data_byte,
  input  logic                     in_final_byte,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DIFF_W-1:0] out_diff_value,
  input  logic                     out_error,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending
);

  localparam int NODES = TREE_NODES_DEF;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic                     error;
    logic                     last;
  } diff_result_t;

  logic [1:0]       branch_flags [NODES];
  logic [SYM_W-1:0] leaf_extra [NODES];
  int unsigned      walk_at;
  bit               in_extra;
  int unsigned      extra_left_n;
  int unsigned      extra_acc;
  int unsigned      extra_n;
  diff_result_t     expected_diffs [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic restart_walk();
    walk_at      = 0;
    in_extra     = 1'b0;
    extra_left_n = 0;
    extra_acc    = 0;
    extra_n      = 0;
  endtask

  task automatic add_code_path(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] bits,
                               input logic [SYM_W-1:0] sym);
    int unsigned code;
    int unsigned node;
    int unsigned dir;
    if (len == 0 || len > MAX_CODE_BITS) return;
    code = bits >> (BYTE_W - len);
    node = 0;
    for (int i = 0; i < len; i++) node = 2 * node + 1 + ((code >> (len - 1 - i)) & 1);
    if (node >= NODES) return;
    node = 0;
    for (int i = 0; i < len; i++) begin
      dir = (code >> (len - 1 - i)) & 1;
      branch_flags[node][dir] = 1'b1;
      node = 2 * node + 1 + dir;
    end
    leaf_extra[node] = (sym > MAX_EXTRA_BITS) ? SYM_W'(MAX_EXTRA_BITS) : sym;
  endtask

  task automatic predict_diffs(input hdd_mode_e mode, input logic [LEN_W-1:0] len,
                               input logic [BYTE_W-1:0] bits, input logic [SYM_W-1:0] sym,
                               input logic [BYTE_W-1:0] dbyte, input logic fin);
    diff_result_t batch [$];
    int unsigned  kid;
    int unsigned  sym_n;
    int           val;
    logic         b;
    if (mode == HDD_LOAD) begin
      add_code_path(len, bits, sym);
      return;
    end
    if (!in_extra && walk_at == 0 && branch_flags[0] == 2'b00) begin
      batch.push_back('{diff: '0, error: 1'b1, last: 1'b0});
    end else begin
      for (int k = BYTE_W - 1; k >= 0; k--) begin
        b = dbyte[k];
        if (in_extra) begin
          extra_acc = ((extra_acc << 1) | b) & 32'hFFFF;
          if (extra_left_n > 0) extra_left_n--;
          if (extra_left_n == 0) begin
            val = int'(extra_acc);
            if (((extra_acc >> (extra_n - 1)) & 1) == 0) val = val - ((1 << extra_n) - 1);
            batch.push_back('{diff: DIFF_W'(val), error: 1'b0, last: 1'b0});
            restart_walk();
          end
          continue;
        end
        if (walk_at >= NODES || branch_flags[walk_at][b] == 1'b0) begin
          batch.push_back('{diff: '0, error: 1'b1, last: 1'b0});
          walk_at = 0;
          continue;
        end
        kid = 2 * walk_at + 1 + b;
        if (kid >= NODES) begin
          batch.push_back('{diff: '0, error: 1'b1, last: 1'b0});
          walk_at = 0;
          continue;
        end
        if (branch_flags[kid] != 2'b00) begin
          walk_at = kid;
          continue;
        end
        sym_n   = leaf_extra[kid];
        walk_at = 0;
        if (sym_n == NO_SYMBOL || sym_n > MAX_EXTRA_BITS) begin
          batch.push_back('{diff: '0, error: 1'b1, last: 1'b0});
        end else if (sym_n == 0) begin
          batch.push_back('{diff: '0, error: 1'b0, last: 1'b0});
        end else begin
          in_extra     = 1'b1;
          extra_left_n = sym_n;
          extra_n      = sym_n;
          extra_acc    = 0;
        end
      end
      if (fin && (in_extra || walk_at != 0)) batch.push_back('{diff: '0, error: 1'b1, last: 1'b0});
    end
    if (fin) restart_walk();
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_diffs.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    diff_result_t want;
    if (!rst_n) begin
      for (int n = 0; n < NODES; n++) begin
        branch_flags[n] = 2'b00;
        leaf_extra[n]   = NO_SYMBOL;
      end
      restart_walk();
      expected_diffs.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_diffs(hdd_mode_e'(in_mode), in_code_length, in_code_bits, in_symbol,
                      in_data_byte, in_final_byte);
      end
      if (out_valid && !out_stall) begin
        if (expected_diffs.size() == 0) begin
          report($sformatf("result diff %0d error %0b with nothing expected",
                           out_diff_value, out_error));
        end else begin
          want = expected_diffs.pop_front();
          if (out_diff_value !== want.diff)
            report($sformatf("diff_value got %0d want %0d", out_diff_value, want.diff));
          if (out_error !== want.error)
            report($sformatf("error got %0b want %0b", out_error, want.error));
          if (out_last !== want.last)
            report($sformatf("last got %0b want %0b", out_last, want.last));
        end
      end
    end
    pending = expected_diffs.size();
  end

endmodule

FILE: tb/tb_huffman_difference_decoder.sv
`timescale 1ns / 1ps
// Top of the Huffman difference decoder testbench: clock, reset, stimulus, stalls and verdict.
module tb_huffman_difference_decoder;
  import hdd_pkg::*;
  import hdd_tb_pkg::*;

  localparam int ITEMS       = 260;
  localparam int HOLD_AT     = 110;
  localparam int CALM_AFTER  = 215;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 40;
  localparam int LIMIT       = 250000;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic                     in_mode        = 1'b0;
  logic [LEN_W-1:0]         in_code_length = '0;
  logic [BYTE_W-1:0]        in_code_bits   = '0;
  logic [SYM_W-1:0]         in_symbol      = '0;
  logic [BYTE_W-1:0]        in_data_byte   = '0;
  logic                     in_final_byte  = 1'b0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic signed [DIFF_W-1:0] out_diff_value;
  logic                     out_error;
  logic                     out_last;

  int fail_count;
  int pending;
  int cycles     = 0;
  int sent_items = 0;
  bit gaps_on    = 1'b1;
  bit stall_on   = 1'b1;
  bit hold_done  = 1'b0;

  int unsigned code_len [$];
  int unsigned code_val [$];
  int unsigned code_extra [$];

  huffman_difference_decoder uut (.*);

  hdd_checker chk (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic offer(input hdd_mode_e mode, input logic [LEN_W-1:0] len,
                       input logic [BYTE_W-1:0] bits, input logic [SYM_W-1:0] sym,
                       input logic [BYTE_W-1:0] dbyte, input logic fin);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_code_length <= len;
    in_code_bits   <= bits;
    in_symbol      <= sym;
    in_data_byte   <= dbyte;
    in_final_byte  <= fin;
    do @(posedge clk); while (in_stall);
    if (mode == HDD_DATA || (len != 0 && len <= MAX_CODE_BITS)) sent_items++;
  endtask

  task automatic load_code(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] bits,
                           input logic [SYM_W-1:0] sym);
    offer(HDD_LOAD, len, bits, sym, BYTE_W'($urandom_range(0, 255)),
          1'($urandom_range(0, 1)));
  endtask

  task automatic feed_byte(input logic [BYTE_W-1:0] dbyte, input logic fin);
    offer(HDD_DATA, LEN_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)),
          SYM_W'($urandom_range(0, 31)), dbyte, fin);
  endtask

  task automatic reload_symbols();
    logic [SYM_W-1:0] sym;
    int unsigned      l;
    foreach (code_len[i]) begin
      l   = code_len[i];
      sym = ($urandom_range(0, 5) == 0) ? SYM_W'($urandom_range(17, 31))
                                        : SYM_W'($urandom_range(0, 16));
      code_extra[i] = (sym > MAX_EXTRA_BITS) ? MAX_EXTRA_BITS : sym;
      load_code(LEN_W'(l),
                BYTE_W'((code_val[i] << (8 - l)) | ($urandom() & ((1 << (8 - l)) - 1))), sym);
    end
  endtask

  // canonical codes under a leading 1, clear of the fixed table under a leading 0
  task automatic build_table();
    int unsigned code;
    int unsigned len;
    int unsigned n;
    code_len.delete();
    code_val.delete();
    code_extra.delete();
    n    = $urandom_range(1, 12);
    code = 0;
    len  = 1;
    for (int i = 0; i < n; i++) begin
      while (len < 7 && ($urandom_range(0, 2) == 0 || code + 1 >= (1 << len))) begin
        code = code << 1;
        len++;
      end
      if (code >= (1 << len)) break;
      code_len.push_back(len + 1);
      code_val.push_back((1 << len) | code);
      code_extra.push_back(0);
      code++;
    end
    reload_symbols();
  endtask

  task automatic send_stream(input int n_sym, input bit corrupt);
    bit               stream [$];
    int               e;
    int               pos;
    logic [BYTE_W-1:0] b;
    repeat (n_sym) begin
      e = $urandom_range(0, code_len.size() - 1);
      for (int i = code_len[e] - 1; i >= 0; i--) stream.push_back(1'((code_val[e] >> i) & 1));
      repeat (code_extra[e]) stream.push_back(1'($urandom_range(0, 1)));
    end
    if (corrupt) begin
      pos = $urandom_range(0, stream.size() - 1);
      stream[pos] = !stream[pos];
    end
    while (stream.size() % 8 != 0) stream.push_back(1'($urandom_range(0, 1)));
    for (int k = 0; k < stream.size(); k += 8) begin
      for (int j = 0; j < 8; j++) b[7 - j] = stream[k + j];
      feed_byte(b, (k + 8 == stream.size()) && $urandom_range(0, 7) != 0);
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (!hold_done && sent_items >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    feed_byte(8'hA5, 1'b0);
    feed_byte(8'h00, 1'b1);
    load_code(4'd0, 8'hFF, 5'd31);
    load_code(4'd15, 8'h00, 5'd0);
    load_code(4'd9, 8'hFF, 5'd16);
    load_code(4'd2, 8'h00, 5'd0);
    load_code(4'd3, 8'h5F, 5'd3);
    load_code(4'd4, 8'h60, 5'd16);
    load_code(4'd8, 8'h70, 5'd31);
    load_code(4'd8, 8'h7F, 5'd1);
    feed_byte(8'h00, 1'b0);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'h4B, 1'b1);
    feed_byte(8'h6F, 1'b0);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'hF0, 1'b1);
    feed_byte(8'h60, 1'b0);
    feed_byte(8'h00, 1'b0);
    feed_byte(8'h00, 1'b1);
    feed_byte(8'h70, 1'b0);
    feed_byte(8'h80, 1'b0);
    feed_byte(8'h01, 1'b1);
    feed_byte(8'h7F, 1'b0);
    feed_byte(8'h3F, 1'b1);
    feed_byte(8'h01, 1'b0);
    load_code(4'd6, 8'h78, 5'd5);
    feed_byte(8'hEA, 1'b1);

    build_table();
    while (sent_items < ITEMS) begin
      if (sent_items >= CALM_AFTER) begin
        gaps_on  = 1'b0;
        stall_on = 1'b0;
      end
      case ($urandom_range(0, 19))
        0:       load_code(LEN_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)),
                           SYM_W'($urandom_range(0, 31)));
        1, 2:    feed_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        3:       reload_symbols();
        4, 5:    send_stream($urandom_range(1, 4), 1'b1);
        default: send_stream($urandom_range(1, 6), 1'b0);
      endcase
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
